FILE: hdl/des_pkg.sv
// Package with the DES permutation tables, S-boxes and round helpers.
`timescale 1ns / 1ps
package des_pkg;

    localparam int unsigned NumRounds = 16;
    localparam int unsigned BlockW    = 64;

    // Rotation amount per round: 1 for rounds 1, 2, 9 and 16, else 2.
    localparam logic [15:0] RotOne = 16'b1100_0000_1000_0001;

    typedef logic [7:0] t_tab64 [64];
    typedef logic [7:0] t_tab56 [56];
    typedef logic [7:0] t_tab48 [48];
    typedef logic [7:0] t_tab32 [32];
    typedef logic [3:0] t_sbox  [512];

    localparam t_tab64 TabIp = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam t_tab64 TabFp = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam t_tab48 TabE = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam t_tab32 TabP = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam t_tab56 TabPc1 = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
        61,53,45,37,29,21,13,5,28,20,12,4};
    localparam t_tab48 TabPc2 = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    localparam t_sbox TabS = '{
        14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13,
        15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9,
        10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12,
        7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14,
        2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3,
        12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13,
        4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12,
        13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,5,6,11,3};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TabIp[i]];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64-TabFp[i]];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64-TabPc1[i]];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56-TabPc2[i]];
        return r;
    endfunction

    // Rotate both 28-bit halves of a C/D word left by one or two.
    function automatic logic [55:0] rot_cd(input logic [55:0] cd, input logic one);
        logic [27:0] c;
        logic [27:0] d;
        c = cd[55:28];
        d = cd[27:0];
        if (one) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
        end else begin
            c = {c[25:0], c[27:26]};
            d = {d[25:0], d[27:26]};
        end
        return {c, d};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32-TabE[i]];
        x = x ^ k;
        for (int b = 0; b < 8; b++) begin
            six = x[47-6*b -: 6];
            s[31-4*b -: 4] = TabS[b*64 + {six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-TabP[i]];
        return p;
    endfunction

endpackage

FILE: hdl/des_block_cipher_unit.sv
// DES ECB engine: one Feistel round per pipeline stage, with a precomputed key schedule.
// Stages from input transfer to result valid: IP stage, 16 rounds, FP stage.
// Throughput: one block per cycle while not stalled; the 16 rounds are unrolled.
// A stall at the output holds each valid stage back to the nearest bubble; that bubble is filled.
// Round keys are rebuilt from the key register r_key and registered in r_rk after a key write.
// Reset (synchronous, active low) clears the key and all stage valid bits.
`timescale 1ns / 1ps
module des_block_cipher_unit
    import des_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [63:0] i_block_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_block_out
);

    localparam int unsigned NumStg = NumRounds + 2;

    logic [63:0] r_key;
    logic [47:0] r_rk [NumRounds];
    logic [47:0] n_rk [NumRounds];

    logic        r_vld [NumStg];
    logic        r_dec [NumRounds+1];
    logic [31:0] r_l   [NumRounds+1];
    logic [31:0] r_r   [NumRounds+1];
    logic        adv   [NumStg];
    logic [63:0] w_ip;
    logic [63:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            r_key <= i_cfg_data;
        end
    end

    // Key schedule is a chain of rotations (wiring) plus one PC-2 each.
    always_comb begin
        logic [55:0] cd;
        cd = perm_pc1(r_key);
        for (int i = 0; i < NumRounds; i++) begin
            cd = rot_cd(cd, RotOne[15-i]);
            n_rk[i] = perm_pc2(cd);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk <= n_rk;
    end

    // Stage advances when it holds nothing or the next stage moves on.
    always_comb begin
        adv[NumStg-1] = !r_vld[NumStg-1] || !i_stall;
        for (int s = NumStg - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_stall = !adv[0];
    assign w_ip    = perm_ip(i_block_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NumStg; s++) r_vld[s] <= 1'b0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NumStg; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dec[0] <= i_cmd;
            r_l[0]   <= w_ip[63:32];
            r_r[0]   <= w_ip[31:0];
        end
        for (int s = 1; s <= NumRounds; s++) begin
            if (adv[s]) begin
                r_dec[s] <= r_dec[s-1];
                r_l[s]   <= r_r[s-1];
                r_r[s]   <= r_l[s-1] ^ feistel(r_r[s-1],
                    r_dec[s-1] ? r_rk[NumRounds-s] : r_rk[s-1]);
            end
        end
        if (adv[NumStg-1]) begin
            r_out <= perm_fp({r_r[NumRounds], r_l[NumRounds]});
        end
    end

    assign o_valid     = r_vld[NumStg-1];
    assign o_block_out = r_out;

endmodule
